### rtl/fsla_pkg.sv
// Shared constants and types of the fixed-slot free-list allocator.
`timescale 1ns / 1ps

package fsla_pkg;

  localparam int POOL_SLOTS = 1024;
  localparam int SLOT_W     = 10;
  localparam int CNT_W      = 11;

  localparam logic [CNT_W-1:0]  POOL_CNT  = CNT_W'(POOL_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_SLOTS - 1);

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_EMPTY          = 2'd1,
    ST_NONE_ALLOCATED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CS_CLEAR,
    CS_RUN,
    CS_REFILL
  } ctrl_state_t;

  typedef struct packed {
    logic [SLOT_W-1:0] granted_slot;
    status_t           status;
    logic [CNT_W-1:0]  allocated_count;
    logic [CNT_W-1:0]  free_count;
  } result_t;

  // One link memory word: the tail marker above the link.
  typedef struct packed {
    logic              link_valid;
    logic [SLOT_W-1:0] link;
  } link_word_t;

endpackage

### rtl/fixed_slot_free_list_allocator.sv
// Fixed-slot free-list allocator: LIFO free list of pool slots with a link memory.
`timescale 1ns / 1ps

// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready   | in_req_type, in_slot_index
// out     | output    | out_valid / out_ready | out_granted_slot, out_status,
//         |           |                       | out_allocated_count, out_free_count
//
// Every request gives exactly one result, in request order.
// A successful allocate is followed by a refill state: the new head's link is read
// from the synchronous link memory as the request is accepted and copied into the
// prefetched link in the cycle after. A free or a refused request needs no refill,
// since the pushed slot's link is the old head. After reset a clearing pass over all
// POOL_SLOTS (1024) slots writes the initial chain; no request is accepted until it is done.
// The output register and a one-entry skid buffer let a request be accepted while
// an earlier result waits. Apart from the clearing pass and the refill state after
// a successful allocate, in_ready drops only when the skid buffer is full.

module fixed_slot_free_list_allocator (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [fsla_pkg::SLOT_W-1:0] in_slot_index,

  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fsla_pkg::SLOT_W-1:0] out_granted_slot,
  output logic [1:0]                  out_status,
  output logic [fsla_pkg::CNT_W-1:0]  out_allocated_count,
  output logic [fsla_pkg::CNT_W-1:0]  out_free_count
);

  // Control state.
  fsla_pkg::ctrl_state_t state_r, state_nxt;
  logic [fsla_pkg::SLOT_W-1:0] clr_cnt_r;
  logic                        clr_last;

  // Head of the free list, together with a prefetched copy of its link word so
  // that a pop never waits on the memory for the new head itself.
  logic [fsla_pkg::SLOT_W-1:0] head_r;
  logic                        head_valid_r;
  logic [fsla_pkg::SLOT_W-1:0] head_link_r;
  logic                        head_link_valid_r;
  logic [fsla_pkg::CNT_W-1:0]  in_use_r;
  logic [fsla_pkg::CNT_W-1:0]  in_use_nxt;

  // Link memory.
  fsla_pkg::link_word_t        link_mem [fsla_pkg::POOL_SLOTS];
  fsla_pkg::link_word_t        rd_data_r;
  fsla_pkg::link_word_t        mem_wdata;
  logic [fsla_pkg::SLOT_W-1:0] mem_waddr;
  logic                        mem_we;
  logic                        mem_re;

  // Output register and skid buffer.
  fsla_pkg::result_t out_r, skid_r, res;
  logic              out_valid_r, skid_valid_r;

  logic accept;
  logic pop_ok, push_ok;
  logic run_ready;

  assign clr_last = (clr_cnt_r == fsla_pkg::LAST_SLOT);
  assign accept   = in_valid && in_ready;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fsla_pkg::CS_CLEAR: begin
        if (clr_last) begin
          state_nxt = fsla_pkg::CS_RUN;
        end
      end
      fsla_pkg::CS_RUN: begin
        if (accept && pop_ok) begin
          state_nxt = fsla_pkg::CS_REFILL;
        end
      end
      fsla_pkg::CS_REFILL: begin
        state_nxt = fsla_pkg::CS_RUN;
      end
      default: begin
        state_nxt = fsla_pkg::CS_CLEAR;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    run_ready = 1'b0;
    case (state_r)
      fsla_pkg::CS_RUN:    run_ready = 1'b1;
      fsla_pkg::CS_CLEAR:  run_ready = 1'b0;
      fsla_pkg::CS_REFILL: run_ready = 1'b0;
      default:             run_ready = 1'b0;
    endcase
  end

  assign in_ready = run_ready && !skid_valid_r;

  // Request decode. An allocate is refused when the list is empty or every
  // slot is already counted as in use; a free is refused when nothing is.
  always_comb begin
    pop_ok  = (in_req_type == fsla_pkg::REQ_ALLOC) && head_valid_r &&
              (in_use_r < fsla_pkg::POOL_CNT);
    push_ok = (in_req_type == fsla_pkg::REQ_FREE) && (in_use_r != '0);

    in_use_nxt = in_use_r;
    if (pop_ok) begin
      in_use_nxt = in_use_r + fsla_pkg::CNT_W'(1);
    end else if (push_ok) begin
      in_use_nxt = in_use_r - fsla_pkg::CNT_W'(1);
    end

    res.granted_slot    = pop_ok ? head_r : '0;
    res.allocated_count = in_use_nxt;
    res.free_count      = fsla_pkg::POOL_CNT - in_use_nxt;
    if (in_req_type == fsla_pkg::REQ_ALLOC) begin
      res.status = pop_ok ? fsla_pkg::ST_OK : fsla_pkg::ST_EMPTY;
    end else begin
      res.status = push_ok ? fsla_pkg::ST_OK : fsla_pkg::ST_NONE_ALLOCATED;
    end
  end

  // Memory port selection: the clearing pass writes the initial chain, a
  // free writes the old head as the pushed slot's link.
  always_comb begin
    if (state_r == fsla_pkg::CS_CLEAR) begin
      mem_we               = 1'b1;
      mem_waddr            = clr_cnt_r;
      mem_wdata.link       = clr_last ? '0 : clr_cnt_r + fsla_pkg::SLOT_W'(1);
      mem_wdata.link_valid = !clr_last;
    end else begin
      mem_we               = accept && push_ok;
      mem_waddr            = in_slot_index;
      mem_wdata.link       = head_r;
      mem_wdata.link_valid = head_valid_r;
    end
    mem_re = accept && pop_ok;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      // The prefetched link is the new head; fetch its own link word.
      rd_data_r <= link_mem[head_link_r];
    end
  end

  // Control and list state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= fsla_pkg::CS_CLEAR;
      clr_cnt_r         <= '0;
      head_r            <= '0;
      head_valid_r      <= 1'b1;
      head_link_r       <= fsla_pkg::SLOT_W'(1);
      head_link_valid_r <= 1'b1;
      in_use_r          <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == fsla_pkg::CS_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + fsla_pkg::SLOT_W'(1);
      end
      if (state_r == fsla_pkg::CS_REFILL) begin
        head_link_r       <= rd_data_r.link;
        head_link_valid_r <= rd_data_r.link_valid;
      end
      if (accept) begin
        in_use_r <= in_use_nxt;
        if (pop_ok) begin
          head_r       <= head_link_r;
          head_valid_r <= head_link_valid_r;
        end else if (push_ok) begin
          head_r            <= in_slot_index;
          head_valid_r      <= 1'b1;
          head_link_r       <= head_r;
          head_link_valid_r <= head_valid_r;
        end
      end
    end
  end

  // Output register with skid buffer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (accept) begin
        out_r <= res;
      end
    end else if (accept) begin
      skid_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_granted_slot    = out_r.granted_slot;
  assign out_status          = out_r.status;
  assign out_allocated_count = out_r.allocated_count;
  assign out_free_count      = out_r.free_count;

  // The in-use count never passes the pool size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_use_r <= fsla_pkg::POOL_CNT)
    else $error("in-use count exceeds pool size");

  // A granted allocate is always followed by the link refill state.
  a_pop_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && pop_ok) |=> (state_r == fsla_pkg::CS_REFILL))
    else $error("granted allocate not followed by refill");

  // The skid buffer only fills behind a stalled output register.
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid buffer holds a result with the output register empty");

  // No result appears while the clearing pass runs.
  a_no_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fsla_pkg::CS_CLEAR) |-> !out_valid_r)
    else $error("result during clearing pass");

  // A refused allocate leaves the list untouched.
  a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req_type == fsla_pkg::REQ_ALLOC) && !pop_ok) |=>
      ($stable(head_r) && $stable(in_use_r)))
    else $error("refused allocate changed the list");

endmodule

### verif/tb_fixed_slot_free_list_allocator.sv
// Testbench for the fixed-slot free-list allocator: directed, stress and random checks.
`timescale 1ns / 1ps

// The bench drives allocate and free requests into the allocator over the
// valid/ready input channel. It keeps its own copy of the free list, the link
// memory and the in-use count, and it works out the expected result for each
// request at the edge where the request is accepted. A separate receiver
// process stalls the result channel at random. It compares every accepted
// result, field by field, with the oldest expected result in the queue.
//
// Test order:
//   directed requests : free with nothing allocated, index extremes, a double
//                       free, and the self-linked list that a double free leaves
//   random traffic    : allocates and frees, the frees mostly of slots that are
//                       really held, plus noise (random indexes, double frees,
//                       frees while idle), run under three idling mixes in turn
//   backpressure      : the receiver holds off for a long stretch while requests
//                       keep coming, so the skid buffer fills and in_ready drops
//   pool drain        : allocate until the pool is exhausted, then hit the
//                       pool-empty case, refill a little and empty it again

module tb_fixed_slot_free_list_allocator;

  localparam int CLK_HALF_NS = 10;
  localparam int RESET_CYCLES = 11;
  // Margin after the last test. It catches stray results.
  localparam int SETTLE_CYCLES = 16;
  // Fixed run limit. It covers the clearing pass after reset plus well over a
  // thousand requests under heavy stalls, with a wide margin.
  localparam longint RUN_LIMIT_NS = 64'd10_000_000;
  // The pool drain alone needs about a thousand allocates, so the random
  // part stays short.
  localparam int RANDOM_REQUESTS = 300;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic                        in_req_type;
  logic [fsla_pkg::SLOT_W-1:0] in_slot_index;
  logic                        out_valid;
  logic                        out_ready;
  logic [fsla_pkg::SLOT_W-1:0] out_granted_slot;
  logic [1:0]                  out_status;
  logic [fsla_pkg::CNT_W-1:0]  out_allocated_count;
  logic [fsla_pkg::CNT_W-1:0]  out_free_count;

  // Predicted allocator state. It mirrors the link memory, the tail markers,
  // the head of the free list and the in-use count.
  logic [fsla_pkg::SLOT_W-1:0] pred_link [fsla_pkg::POOL_SLOTS];
  logic                        pred_link_ok [fsla_pkg::POOL_SLOTS];
  logic [fsla_pkg::SLOT_W-1:0] pred_head;
  logic                        pred_head_ok;
  logic [fsla_pkg::CNT_W-1:0]  pred_in_use;

  fsla_pkg::result_t           expected_results[$];
  logic [fsla_pkg::SLOT_W-1:0] held_slots[$];

  int tx_idle_pct;
  int rx_stall_pct;
  int rx_hold_left;
  int error_count;

  fixed_slot_free_list_allocator uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_slot_index       (in_slot_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_granted_slot    (out_granted_slot),
    .out_status          (out_status),
    .out_allocated_count (out_allocated_count),
    .out_free_count      (out_free_count)
  );

  initial begin
    clk = 1'b0;
    forever begin
      #CLK_HALF_NS clk = ~clk;
    end
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("FAIL fixed_slot_free_list_allocator");
    $finish;
  end

  // After reset the free list is the chain 0, 1, ..., POOL_SLOTS-1. Only the
  // last slot has its tail marker clear.
  task automatic reset_prediction();
    for (int i = 0; i < fsla_pkg::POOL_SLOTS; i++) begin
      pred_link[i]    = fsla_pkg::SLOT_W'(i + 1);
      pred_link_ok[i] = (i != fsla_pkg::POOL_SLOTS - 1);
    end
    pred_head    = '0;
    pred_head_ok = 1'b1;
    pred_in_use  = '0;
  endtask

  // Applies one accepted request to the predicted state and returns its result.
  // The slot index is as wide as the pool, so it needs no wrapping.
  function automatic fsla_pkg::result_t predict_request(fsla_pkg::req_t req,
                                                        logic [fsla_pkg::SLOT_W-1:0] idx);
    fsla_pkg::result_t           res;
    logic [fsla_pkg::SLOT_W-1:0] popped;
    res.granted_slot = '0;
    res.status       = fsla_pkg::ST_OK;
    if (req == fsla_pkg::REQ_ALLOC) begin
      if (!pred_head_ok || pred_in_use >= fsla_pkg::POOL_CNT) begin
        res.status = fsla_pkg::ST_EMPTY;
      end else begin
        popped           = pred_head;
        res.granted_slot = popped;
        pred_head        = pred_link[popped];
        pred_head_ok     = pred_link_ok[popped];
        pred_in_use      = pred_in_use + fsla_pkg::CNT_W'(1);
      end
    end else if (pred_in_use == '0) begin
      res.status = fsla_pkg::ST_NONE_ALLOCATED;
    end else begin
      // A push links the slot to the old head, even when the slot is already
      // on the list. A double free therefore ends in a self-link.
      pred_link[idx]    = pred_head;
      pred_link_ok[idx] = pred_head_ok;
      pred_head         = idx;
      pred_head_ok      = 1'b1;
      pred_in_use       = pred_in_use - fsla_pkg::CNT_W'(1);
    end
    res.allocated_count = pred_in_use;
    res.free_count      = fsla_pkg::POOL_CNT - pred_in_use;
    return res;
  endfunction

  // Offers one request, with an optional random gap first. When the request is
  // accepted, the task records its expected result. in_valid stays high when
  // the task returns, so the next request can follow back to back.
  task automatic send_request(fsla_pkg::req_t req, logic [fsla_pkg::SLOT_W-1:0] idx);
    fsla_pkg::result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_slot_index <= idx;
    do begin
      @(posedge clk);
    end while (!in_ready);
    res = predict_request(req, idx);
    expected_results.insert(expected_results.size(), res);
    if (req == fsla_pkg::REQ_ALLOC && res.status == fsla_pkg::ST_OK) begin
      held_slots.insert(held_slots.size(), res.granted_slot);
    end
  endtask

  // Stops offering requests and waits until every expected result has arrived.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_directed_requests();
    // Right after reset nothing is allocated, so both frees are refused.
    send_request(fsla_pkg::REQ_FREE, '0);
    send_request(fsla_pkg::REQ_FREE, fsla_pkg::LAST_SLOT);
    send_request(fsla_pkg::REQ_ALLOC, fsla_pkg::LAST_SLOT);
    send_request(fsla_pkg::REQ_ALLOC, '0);
    send_request(fsla_pkg::REQ_ALLOC, 10'h2AA);
    send_request(fsla_pkg::REQ_ALLOC, 10'h155);
    // Return the highest index. It was never handed out, but a push is a push.
    send_request(fsla_pkg::REQ_FREE, fsla_pkg::LAST_SLOT);
    send_request(fsla_pkg::REQ_FREE, '0);
    // Free the same slot twice. The second push makes slot 1 point to itself,
    // so the following allocates hand out slot 1 repeatedly.
    send_request(fsla_pkg::REQ_FREE, 10'd1);
    send_request(fsla_pkg::REQ_FREE, 10'd1);
    send_request(fsla_pkg::REQ_ALLOC, 10'h3FF);
    send_request(fsla_pkg::REQ_ALLOC, 10'h000);
    send_request(fsla_pkg::REQ_ALLOC, 10'h155);
    send_request(fsla_pkg::REQ_FREE, 10'h2AA);
    send_request(fsla_pkg::REQ_FREE, 10'h155);
    send_request(fsla_pkg::REQ_FREE, 10'h3FF);
    send_request(fsla_pkg::REQ_FREE, 10'd2);
    send_request(fsla_pkg::REQ_FREE, 10'd3);
    send_request(fsla_pkg::REQ_FREE, 10'd0);
    send_request(fsla_pkg::REQ_ALLOC, 10'd0);
    wait_for_results();
  endtask

  // Most frees return a slot that is really held. Some use a random index,
  // which can free a slot twice, and some come when nothing is allocated.
  task automatic test_random_traffic(int count, int tx_pct, int rx_pct);
    int                          pos;
    logic [fsla_pkg::SLOT_W-1:0] idx;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int n = 0; n < count; n++) begin
      idx = fsla_pkg::SLOT_W'($urandom);
      if ($urandom_range(99) < (held_slots.size() == 0 ? 85 : 52)) begin
        send_request(fsla_pkg::REQ_ALLOC, idx);
      end else begin
        if (held_slots.size() != 0 && $urandom_range(99) < 80) begin
          pos = $urandom_range(held_slots.size() - 1);
          idx = held_slots[pos];
          held_slots.delete(pos);
        end
        send_request(fsla_pkg::REQ_FREE, idx);
      end
    end
    wait_for_results();
  endtask

  // The receiver stalls for a long stretch. The sender keeps offering requests
  // until the output register and the skid buffer are full. Then the sender
  // waits on in_ready, and at the end it waits until everything has drained.
  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_left = 60;
    for (int n = 0; n < 12; n++) begin
      send_request(n[0] ? fsla_pkg::REQ_FREE : fsla_pkg::REQ_ALLOC,
                   fsla_pkg::SLOT_W'($urandom));
    end
    wait_for_results();
  endtask

  // Allocates until the pool is exhausted, then checks the pool-empty case, which
  // comes from a full count or from a free list whose tail has been reached.
  task automatic test_pool_drain();
    int guard;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    guard = 0;
    while (pred_head_ok && pred_in_use < fsla_pkg::POOL_CNT &&
           guard < 2 * fsla_pkg::POOL_SLOTS) begin
      send_request(fsla_pkg::REQ_ALLOC, fsla_pkg::SLOT_W'($urandom));
      guard++;
    end
    repeat (3) send_request(fsla_pkg::REQ_ALLOC, fsla_pkg::SLOT_W'($urandom));
    send_request(fsla_pkg::REQ_FREE, fsla_pkg::LAST_SLOT);
    send_request(fsla_pkg::REQ_FREE, '0);
    send_request(fsla_pkg::REQ_FREE, 10'h2AA);
    repeat (4) send_request(fsla_pkg::REQ_ALLOC, '0);
    wait_for_results();
  endtask

  // Result receiver and checker. Values read right after the edge are the
  // values that were present at the edge, because the block updates its
  // outputs with nonblocking assignments.
  initial begin
    fsla_pkg::result_t want;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: granted_slot %0d status %0d", out_granted_slot,
                 out_status);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_granted_slot !== want.granted_slot) begin
            $error("granted_slot: expected %0d, actual %0d", want.granted_slot,
                   out_granted_slot);
            error_count++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            error_count++;
          end
          if (out_allocated_count !== want.allocated_count) begin
            $error("allocated_count: expected %0d, actual %0d", want.allocated_count,
                   out_allocated_count);
            error_count++;
          end
          if (out_free_count !== want.free_count) begin
            $error("free_count: expected %0d, actual %0d", want.free_count,
                   out_free_count);
            error_count++;
          end
        end
      end
      if (rx_hold_left > 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    error_count   = 0;
    rx_hold_left  = 0;
    tx_idle_pct   = 18;
    rx_stall_pct  = 62;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_req_type   <= fsla_pkg::REQ_ALLOC;
    in_slot_index <= '0;
    reset_prediction();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // The block's clearing pass holds in_ready low. The first request waits
    // on the handshake until the pass is done.
    test_directed_requests();
    test_random_traffic(RANDOM_REQUESTS / 3, 18, 62);
    test_random_traffic(RANDOM_REQUESTS / 3, 62, 18);
    test_random_traffic(RANDOM_REQUESTS - 2 * (RANDOM_REQUESTS / 3), 0, 0);
    test_backpressure();
    test_pool_drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("PASS fixed_slot_free_list_allocator");
    end else begin
      $display("FAIL fixed_slot_free_list_allocator");
    end
    $finish;
  end

endmodule
